[rtl/core/scc_pkg.sv]
// Shared types and constants for the serial console with text screen.
// Used by scc_front, scc_back and the top level; no dependencies.
`timescale 1ns / 1ps

package scc_pkg;

  localparam int FIFO_DEPTH_DEF  = 256;
  localparam int SCREEN_ROWS_DEF = 12;
  localparam int SCREEN_COLS_DEF = 78;

  localparam logic [7:0] PORT_STATUS   = 8'h80;
  localparam logic [7:0] PORT_DATA     = 8'h81;
  localparam logic [7:0] STAT_RX_READY = 8'h01;
  localparam logic [7:0] STAT_TX_EMPTY = 8'h02;
  localparam logic [7:0] OPEN_BUS      = 8'hFF;
  localparam logic [6:0] BLANK         = 7'h20;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_BS     = 8'h08;
  localparam logic [7:0] PRINT_FIRST = 8'd32;
  localparam logic [7:0] PRINT_END   = 8'd127;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_PORT_RD = 2'd1,
    CMD_PORT_WR = 2'd2,
    CMD_CELL_RD = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    OP_PUSH     = 4'd0,
    OP_STATUS   = 4'd1,
    OP_POP      = 4'd2,
    OP_OPEN     = 4'd3,
    OP_NOP      = 4'd4,
    OP_CR       = 4'd5,
    OP_LF       = 4'd6,
    OP_BS       = 4'd7,
    OP_PUT      = 4'd8,
    OP_CELL     = 4'd9,
    OP_CELL_OOR = 4'd10
  } op_kind_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [7:0]  data;
    logic [3:0]  row;
    logic [6:0]  col;
  } op_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_status_t;

endpackage

[rtl/core/scc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module scc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/scc_front.sv]
// Front end: accepts input words, classifies them into ops, queues them.
// Depends on scc_pkg.
`timescale 1ns / 1ps

module scc_front #(
  parameter int SCREEN_ROWS = scc_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = scc_pkg::SCREEN_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            command,
  input  logic [7:0]            port,
  input  logic [7:0]            data,
  input  logic [3:0]            cell_row,
  input  logic [6:0]            cell_col,
  input  scc_pkg::back_status_t status,
  output logic                  q_valid,
  output scc_pkg::op_t          q_op
);

  import scc_pkg::*;

  localparam int QD   = 2;
  localparam int QI_W = $clog2(QD);
  localparam int QC_W = $clog2(QD + 1);

  op_t             q_data [QD];
  logic [QI_W-1:0] wr_idx;
  logic [QI_W-1:0] rd_idx;
  logic [QC_W-1:0] count;
  logic            q_full;
  logic            accept;
  op_t             op_in;

  assign q_full   = (count == QC_W'(QD));
  assign in_stall = q_full || status.clearing;
  assign accept   = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign q_op     = q_data[rd_idx];

  always_comb begin
    op_in.data = data;
    op_in.row  = cell_row;
    op_in.col  = cell_col;
    op_in.kind = OP_NOP;
    unique case (command)
      CMD_PUSH: begin
        op_in.kind = OP_PUSH;
      end
      CMD_PORT_RD: begin
        if (port == PORT_STATUS) begin
          op_in.kind = OP_STATUS;
        end else if (port == PORT_DATA) begin
          op_in.kind = OP_POP;
        end else begin
          op_in.kind = OP_OPEN;
        end
      end
      CMD_PORT_WR: begin
        if (port != PORT_DATA) begin
          op_in.kind = OP_NOP;
        end else if (data == CHAR_CR) begin
          op_in.kind = OP_CR;
        end else if (data == CHAR_LF) begin
          op_in.kind = OP_LF;
        end else if (data == CHAR_BS) begin
          op_in.kind = OP_BS;
        end else if (data >= PRINT_FIRST && data < PRINT_END) begin
          op_in.kind = OP_PUT;
        end else begin
          op_in.kind = OP_NOP;
        end
      end
      CMD_CELL_RD: begin
        if (32'(cell_row) < 32'(SCREEN_ROWS) && 32'(cell_col) < 32'(SCREEN_COLS)) begin
          op_in.kind = OP_CELL;
        end else begin
          op_in.kind = OP_CELL_OOR;
        end
      end
      default: begin
        op_in.kind = OP_NOP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_data[wr_idx] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_idx <= wr_idx + 1'b1;
      end
      if (status.pop) begin
        rd_idx <= rd_idx + 1'b1;
      end
      count <= count + QC_W'(accept) - QC_W'(status.pop);
    end
  end

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    status.pop |-> q_valid)
    else $error("op queue popped while empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (rst)
    accept && !status.pop |=> count != '0)
    else $error("accepted word lost from op queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= QC_W'(QD))
    else $error("op queue count past its depth");

endmodule

[rtl/core/scc_back.sv]
// Back end: executes queued ops on the receive FIFO and the text screen.
// Depends on scc_pkg and scc_ram.
`timescale 1ns / 1ps

module scc_back #(
  parameter int FIFO_DEPTH  = scc_pkg::FIFO_DEPTH_DEF,
  parameter int SCREEN_ROWS = scc_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = scc_pkg::SCREEN_COLS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  scc_pkg::op_t          q_op,
  output scc_pkg::back_status_t status,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [7:0]            read_data,
  output logic                  key_dropped,
  output logic [3:0]            cursor_row,
  output logic [6:0]            cursor_col
);

  import scc_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int ROW_W = $clog2(SCREEN_ROWS);
  localparam int COL_W = $clog2(SCREEN_COLS + 1);
  localparam int CELLS = SCREEN_ROWS * SCREEN_COLS;
  localparam int SA_W  = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_RDWAIT = 4'b0100,
    S_SCROLL = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [PTR_W-1:0] wptr, wptr_next;
  logic [PTR_W-1:0] rptr, rptr_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] cur_col, cur_col_next;
  logic [ROW_W-1:0] top, top_next;
  logic [SA_W-1:0]  clear_cnt, clear_cnt_next;
  logic [COL_W-1:0] scroll_cnt, scroll_cnt_next;
  logic [SA_W-1:0]  scroll_base, scroll_base_next;
  logic             rd_src_scr, rd_src_scr_next;

  logic [7:0]       out_rd;
  logic             out_drop;
  logic [ROW_W-1:0] out_row;
  logic [COL_W-1:0] out_col;

  logic             load;
  logic [7:0]       ld_rd;
  logic             ld_drop;
  logic             out_free;
  logic             pop;

  logic             fifo_we;
  logic [7:0]       fifo_rdata;
  logic             scr_we;
  logic [SA_W-1:0]  scr_waddr;
  logic [6:0]       scr_wdata;
  logic [SA_W-1:0]  scr_raddr;
  logic [6:0]       scr_rdata;

  logic [PTR_W-1:0] wnext;
  logic [PTR_W-1:0] rnext;
  logic             nonempty;
  logic [SA_W-1:0]  put_addr;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(FIFO_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [SA_W-1:0] scr_addr(input logic [ROW_W-1:0] lrow,
                                               input logic [COL_W-1:0] lcol,
                                               input logic [ROW_W-1:0] base_row);
    logic [ROW_W:0] sum;
    sum = {1'b0, lrow} + {1'b0, base_row};
    if (sum >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      sum = sum - (ROW_W + 1)'(SCREEN_ROWS);
    end
    return SA_W'(sum) * SA_W'(SCREEN_COLS) + SA_W'(lcol);
  endfunction

  assign wnext     = ring_next(wptr);
  assign rnext     = ring_next(rptr);
  assign nonempty  = (wptr != rptr);
  assign put_addr  = scr_addr(cur_row, cur_col, top);
  assign scr_raddr = scr_addr(ROW_W'(q_op.row), COL_W'(q_op.col), top);
  assign out_free  = !out_valid || !out_stall;

  assign status.pop      = pop;
  assign status.clearing = (state == S_CLEAR);

  scc_ram #(
    .WIDTH (8),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (fifo_we),
    .waddr (wptr),
    .wdata (q_op.data),
    .raddr (rptr),
    .rdata (fifo_rdata)
  );

  scc_ram #(
    .WIDTH (7),
    .DEPTH (CELLS)
  ) u_screen_ram (
    .clk   (clk),
    .we    (scr_we),
    .waddr (scr_waddr),
    .wdata (scr_wdata),
    .raddr (scr_raddr),
    .rdata (scr_rdata)
  );

  always_comb begin
    state_next       = state;
    wptr_next        = wptr;
    rptr_next        = rptr;
    cur_row_next     = cur_row;
    cur_col_next     = cur_col;
    top_next         = top;
    clear_cnt_next   = clear_cnt;
    scroll_cnt_next  = scroll_cnt;
    scroll_base_next = scroll_base;
    rd_src_scr_next  = rd_src_scr;
    load             = 1'b0;
    ld_rd            = '0;
    ld_drop          = 1'b0;
    pop              = 1'b0;
    fifo_we          = 1'b0;
    scr_we           = 1'b0;
    scr_waddr        = put_addr;
    scr_wdata        = q_op.data[6:0];

    unique case (state)
      S_CLEAR: begin
        scr_we         = 1'b1;
        scr_waddr      = clear_cnt;
        scr_wdata      = BLANK;
        clear_cnt_next = clear_cnt + 1'b1;
        if (clear_cnt == SA_W'(CELLS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid && out_free) begin
          pop = 1'b1;
          unique case (q_op.kind)
            OP_PUSH: begin
              load = 1'b1;
              if (wnext != rptr) begin
                fifo_we   = 1'b1;
                wptr_next = wnext;
              end else begin
                ld_drop = 1'b1;
              end
            end
            OP_STATUS: begin
              load  = 1'b1;
              ld_rd = nonempty ? (STAT_TX_EMPTY | STAT_RX_READY) : STAT_TX_EMPTY;
            end
            OP_POP: begin
              if (nonempty) begin
                rptr_next       = rnext;
                rd_src_scr_next = 1'b0;
                state_next      = S_RDWAIT;
              end else begin
                load = 1'b1;
              end
            end
            OP_OPEN: begin
              load  = 1'b1;
              ld_rd = OPEN_BUS;
            end
            OP_CR: begin
              load         = 1'b1;
              cur_col_next = '0;
            end
            OP_BS: begin
              load = 1'b1;
              if (cur_col != '0) begin
                cur_col_next = cur_col - 1'b1;
              end
            end
            OP_PUT: begin
              load = 1'b1;
              if (cur_col < COL_W'(SCREEN_COLS)) begin
                scr_we       = 1'b1;
                cur_col_next = cur_col + 1'b1;
              end
            end
            OP_LF: begin
              cur_col_next = '0;
              if (cur_row == ROW_W'(SCREEN_ROWS - 1)) begin
                // new bottom line is the old top row
                top_next         = (top == ROW_W'(SCREEN_ROWS - 1)) ? '0 : top + 1'b1;
                scroll_base_next = SA_W'(top) * SA_W'(SCREEN_COLS);
                scroll_cnt_next  = '0;
                state_next       = S_SCROLL;
              end else begin
                load         = 1'b1;
                cur_row_next = cur_row + 1'b1;
              end
            end
            OP_CELL: begin
              rd_src_scr_next = 1'b1;
              state_next      = S_RDWAIT;
            end
            default: begin
              load = 1'b1;
            end
          endcase
        end
      end
      S_RDWAIT: begin
        load       = 1'b1;
        ld_rd      = rd_src_scr ? {1'b0, scr_rdata} : fifo_rdata;
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        scr_we          = 1'b1;
        scr_waddr       = scroll_base + SA_W'(scroll_cnt);
        scr_wdata       = BLANK;
        scroll_cnt_next = scroll_cnt + 1'b1;
        if (scroll_cnt == COL_W'(SCREEN_COLS - 1)) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      wptr      <= '0;
      rptr      <= '0;
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      clear_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wptr      <= wptr_next;
      rptr      <= rptr_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      top       <= top_next;
      clear_cnt <= clear_cnt_next;
      out_valid <= load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    scroll_cnt  <= scroll_cnt_next;
    scroll_base <= scroll_base_next;
    rd_src_scr  <= rd_src_scr_next;
    if (load) begin
      out_rd   <= ld_rd;
      out_drop <= ld_drop;
      out_row  <= cur_row_next;
      out_col  <= cur_col_next;
    end
  end

  assign read_data   = out_rd;
  assign key_dropped = out_drop;
  assign cursor_row  = 4'(out_row);
  assign cursor_col  = 7'(out_col);

  a_rdwait_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_RDWAIT |-> !out_valid)
    else $error("read completion with output register still full");

  a_scroll_at_bottom: assert property (@(posedge clk) disable iff (rst)
    state == S_SCROLL |-> cur_row == ROW_W'(SCREEN_ROWS - 1) && cur_col == '0)
    else $error("scroll outside bottom row");

  a_reset_clears: assert property (@(posedge clk)
    $fell(rst) |-> state == S_CLEAR && clear_cnt == '0 && !out_valid)
    else $error("screen clear pass not started after reset");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE && out_free)
    else $error("op taken while back end busy");

endmodule

[rtl/core/serial_console_with_text_screen.sv]
// Serial console top level: front classifier, op queue and back executor.
// Depends on scc_pkg, scc_front, scc_back, scc_ram.
`timescale 1ns / 1ps

// Input channel (in_valid/in_stall) carries one word: command, port, data,
// cell_row, cell_col. Output channel (out_valid/out_stall) returns exactly one
// word per input word: read_data, key_dropped, cursor_row, cursor_col.
// Commands: host key push, CPU port read (0x80 status, 0x81 pop, others 0xFF),
// CPU port write (0x81 prints to the screen), screen cell read.
// A FIFO pop or a cell read waits on a registered RAM read before out_valid
// rises; an LF on the bottom row also blanks the new bottom line of
// SCREEN_COLS cells (78 by default), the worst case per word. Screen scrolling
// moves a row base pointer, not data.
// One word is executed at a time; simple words run back to back at one per
// cycle while out_stall is low. A two-entry op queue lets the front keep
// accepting while a result waits on out_stall, and in_stall rises when the
// queue is full.
// Reset: pointers and cursor return to zero, then a clear pass writes spaces
// to all SCREEN_ROWS*SCREEN_COLS cells, one per cycle, with in_stall held high.
module serial_console_with_text_screen #(
  parameter int FIFO_DEPTH  = scc_pkg::FIFO_DEPTH_DEF,
  parameter int SCREEN_ROWS = scc_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS = scc_pkg::SCREEN_COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] command,
  input  logic [7:0] port,
  input  logic [7:0] data,
  input  logic [3:0] cell_row,
  input  logic [6:0] cell_col,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_data,
  output logic       key_dropped,
  output logic [3:0] cursor_row,
  output logic [6:0] cursor_col
);

  import scc_pkg::*;

  logic         q_valid;
  op_t          q_op;
  back_status_t status;

  scc_front #(
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .port     (port),
    .data     (data),
    .cell_row (cell_row),
    .cell_col (cell_col),
    .status   (status),
    .q_valid  (q_valid),
    .q_op     (q_op)
  );

  scc_back #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .SCREEN_ROWS (SCREEN_ROWS),
    .SCREEN_COLS (SCREEN_COLS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_op        (q_op),
    .status      (status),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_data   (read_data),
    .key_dropped (key_dropped),
    .cursor_row  (cursor_row),
    .cursor_col  (cursor_col)
  );

endmodule

[verif/tb_top.sv]
// Testbench for serial_console_with_text_screen: directed and random console traffic.
// Each result word is checked against a built-in model of the key FIFO and text screen.
// Depends on scc_pkg and the RTL of the console.
`timescale 1ns / 1ps

module tb_top;
  import scc_pkg::*;

  localparam int DEPTH = FIFO_DEPTH_DEF;
  localparam int ROWS  = SCREEN_ROWS_DEF;
  localparam int COLS  = SCREEN_COLS_DEF;

  typedef struct packed {
    logic [7:0] read_data;
    logic       key_dropped;
    logic [3:0] cursor_row;
    logic [6:0] cursor_col;
  } console_out_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [1:0] command   = '0;
  logic [7:0] port      = '0;
  logic [7:0] data      = '0;
  logic [3:0] cell_row  = '0;
  logic [6:0] cell_col  = '0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] read_data;
  logic       key_dropped;
  logic [3:0] cursor_row;
  logic [6:0] cursor_col;

  serial_console_with_text_screen dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .port(port), .data(data), .cell_row(cell_row), .cell_col(cell_col),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .key_dropped(key_dropped),
    .cursor_row(cursor_row), .cursor_col(cursor_col)
  );

  always #6 clk = ~clk;

  // console model
  logic [7:0]  key_mem [DEPTH];
  int unsigned key_wr, key_rd;
  logic [6:0]  screen_mem [ROWS][COLS];
  int unsigned cur_row_m, cur_col_m;

  console_out_t pending_results[$];
  int error_count, words_sent, results_checked, keys_dropped, scroll_count;
  int stall_rate, gap_rate, stall_left;

  function automatic void scroll_screen();
    for (int r = 0; r < ROWS - 1; r++)
      for (int c = 0; c < COLS; c++) screen_mem[r][c] = screen_mem[r + 1][c];
    for (int c = 0; c < COLS; c++) screen_mem[ROWS - 1][c] = BLANK;
    scroll_count++;
  endfunction

  function automatic void put_char(logic [7:0] ch);
    if (ch == CHAR_CR) begin
      cur_col_m = 0;
    end else if (ch == CHAR_LF) begin
      cur_col_m = 0;
      if (cur_row_m + 1 >= ROWS) begin
        scroll_screen();
        cur_row_m = ROWS - 1;
      end else begin
        cur_row_m++;
      end
    end else if (ch == CHAR_BS) begin
      if (cur_col_m > 0) cur_col_m--;
    end else if (ch >= PRINT_FIRST && ch < PRINT_END) begin
      if (cur_col_m < COLS && cur_row_m < ROWS) begin
        screen_mem[cur_row_m][cur_col_m] = ch[6:0];
        cur_col_m++;
      end
    end
  endfunction

  function automatic console_out_t predict_console(logic [1:0] c, logic [7:0] p,
                                                   logic [7:0] d, logic [3:0] r,
                                                   logic [6:0] cc);
    console_out_t res;
    int unsigned nxt;
    res = '0;
    case (c)
      CMD_PUSH: begin
        nxt = (key_wr + 1) % DEPTH;
        if (nxt != key_rd) begin
          key_mem[key_wr] = d;
          key_wr = nxt;
        end else begin
          res.key_dropped = 1'b1;
          keys_dropped++;
        end
      end
      CMD_PORT_RD: begin
        if (p == PORT_STATUS) begin
          res.read_data = STAT_TX_EMPTY | ((key_wr != key_rd) ? STAT_RX_READY : 8'h00);
        end else if (p == PORT_DATA) begin
          if (key_wr != key_rd) begin
            res.read_data = key_mem[key_rd];
            key_rd = (key_rd + 1) % DEPTH;
          end
        end else begin
          res.read_data = OPEN_BUS;
        end
      end
      CMD_PORT_WR: begin
        if (p == PORT_DATA) put_char(d);
      end
      default: begin
        if (r < ROWS && cc < COLS) res.read_data = {1'b0, screen_mem[r][cc]};
      end
    endcase
    res.cursor_row = cur_row_m[3:0];
    res.cursor_col = cur_col_m[6:0];
    return res;
  endfunction

  task automatic send_word(cmd_t c, logic [7:0] p, logic [7:0] d, logic [3:0] r,
                           logic [6:0] cc);
    in_valid <= 1'b1;
    command  <= c;
    port     <= p;
    data     <= d;
    cell_row <= r;
    cell_col <= cc;
    do begin
      @(posedge clk);
    end while (in_stall);
    pending_results.push_back(predict_console(c, p, d, r, cc));
    words_sent++;
    if (gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_results.size() != 0);
  endtask

  task automatic write_char(logic [7:0] ch);
    send_word(CMD_PORT_WR, PORT_DATA, ch, 4'($urandom), 7'($urandom));
  endtask

  task automatic read_cell(int r, int c);
    send_word(CMD_CELL_RD, 8'($urandom), 8'($urandom), 4'(r), 7'(c));
  endtask

  task automatic read_port(logic [7:0] p);
    send_word(CMD_PORT_RD, p, 8'($urandom), 4'($urandom), 7'($urandom));
  endtask

  task automatic push_key(logic [7:0] k);
    send_word(CMD_PUSH, 8'($urandom), k, 4'($urandom), 7'($urandom));
  endtask

  // result checker
  always @(posedge clk) begin : check_word
    console_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no pending expectation");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (read_data !== want.read_data) begin
          $error("read_data: expected %0h, actual %0h", want.read_data, read_data);
          error_count++;
        end
        if (key_dropped !== want.key_dropped) begin
          $error("key_dropped: expected %0d, actual %0d", want.key_dropped, key_dropped);
          error_count++;
        end
        if (cursor_row !== want.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", want.cursor_row, cursor_row);
          error_count++;
        end
        if (cursor_col !== want.cursor_col) begin
          $error("cursor_col: expected %0d, actual %0d", want.cursor_col, cursor_col);
          error_count++;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (rst || stall_rate == 0) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      stall_left--;
      if (stall_left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(1, stall_rate) == 1) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 4);
    end
  end

  task automatic test_reset_screen();
    read_cell(0, 0);
    read_cell(ROWS - 1, COLS - 1);
    read_cell(5, 40);
    read_cell(ROWS, 0);
    read_cell(0, COLS);
    read_cell(15, 127);
  endtask

  task automatic test_port_reads();
    read_port(PORT_STATUS);
    read_port(PORT_DATA);
    read_port(8'h00);
    read_port(8'hFF);
    push_key(8'h00);
    push_key(8'hFF);
    read_port(PORT_STATUS);
    read_port(PORT_DATA);
    read_port(PORT_DATA);
    read_port(PORT_DATA);
  endtask

  task automatic test_screen_codes();
    send_word(CMD_PORT_WR, PORT_STATUS, 8'h5A, 4'($urandom), 7'($urandom));
    write_char(8'h41);
    write_char(8'h20);
    write_char(8'h7E);
    write_char(8'h7F);
    write_char(8'h1F);
    write_char(8'h00);
    write_char(8'hFF);
    read_cell(0, 2);
    repeat (4) write_char(CHAR_BS);
    write_char(8'h42);
    write_char(CHAR_CR);
    write_char(CHAR_LF);
    read_cell(0, 0);
    read_cell(0, 1);
  endtask

  task automatic test_right_edge();
    write_char(CHAR_CR);
    repeat (COLS + 2) write_char(8'($urandom_range(32, 126)));
    read_cell(cur_row_m, COLS - 1);
    write_char(CHAR_BS);
    write_char(8'h23);
    read_cell(cur_row_m, COLS - 1);
    write_char(CHAR_CR);
  endtask

  task automatic test_scroll();
    repeat (ROWS + 2) begin
      write_char(8'($urandom_range(32, 126)));
      write_char(CHAR_LF);
    end
    read_cell(ROWS - 2, 0);
    read_cell(ROWS - 1, 0);
  endtask

  task automatic test_fifo_full();
    repeat (DEPTH + 2) push_key(8'($urandom));
    read_port(PORT_STATUS);
    repeat (DEPTH) read_port(PORT_DATA);
    read_port(PORT_STATUS);
  endtask

  task automatic test_random_traffic(int n, int push_w);
    int pick;
    int sel;
    logic [7:0] p;
    logic [7:0] d;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      sel  = $urandom_range(0, 99);
      if (pick < push_w) begin
        push_key(8'($urandom));
      end else if (pick < push_w + 25) begin
        p = (sel < 45) ? PORT_STATUS : (sel < 90) ? PORT_DATA : 8'($urandom);
        read_port(p);
      end else if (pick < push_w + 40) begin
        if (sel < 85) read_cell($urandom_range(0, ROWS - 1), $urandom_range(0, COLS - 1));
        else read_cell($urandom_range(0, 15), $urandom_range(0, 127));
      end else begin
        if (sel < 55)      d = 8'($urandom_range(32, 126));
        else if (sel < 65) d = CHAR_LF;
        else if (sel < 72) d = CHAR_CR;
        else if (sel < 82) d = CHAR_BS;
        else               d = 8'($urandom);
        p = ($urandom_range(0, 99) < 85) ? PORT_DATA : 8'($urandom);
        send_word(CMD_PORT_WR, p, d, 4'($urandom), 7'($urandom));
      end
    end
  endtask

  initial begin
    key_wr = 0;
    key_rd = 0;
    cur_row_m = 0;
    cur_col_m = 0;
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLS; c++) screen_mem[r][c] = BLANK;
    stall_rate = 0;
    gap_rate = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_reset_screen();
    stall_rate = 5;
    gap_rate = 4;
    test_port_reads();
    wait_idle();
    test_screen_codes();
    test_right_edge();
    stall_rate = 0;
    test_scroll();
    stall_rate = 3;
    test_fifo_full();
    wait_idle();

    stall_rate = 6;
    gap_rate = 5;
    test_random_traffic(340, 15);
    stall_rate = 3;
    gap_rate = 3;
    test_random_traffic(340, 45);
    stall_rate = 0;
    gap_rate = 4;
    test_random_traffic(340, 10);
    wait_idle();
    gap_rate = 0;
    test_random_traffic(340, 20);
    wait_idle();
    repeat (100) @(posedge clk);

    $display("Covered %0d words (%0d results checked): key pushes with %0d drops,",
             words_sent, results_checked, keys_dropped);
    $display("port reads and writes, cell reads and %0d screen scrolls.", scroll_count);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[serial_console_with_text_screen.f]
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/scc_front.sv
rtl/core/scc_back.sv
rtl/core/serial_console_with_text_screen.sv
verif/tb_top.sv
